[hw/rtl/adsr_pkg.sv]
package adsr_pkg;

  // Fixed-point formats
  localparam int TIME_FRAC_BITS = 12;
  localparam int AMP_FRAC_BITS  = 16;

  // Field widths
  localparam int TIME_W  = 19;
  localparam int LEN_W   = 16;
  localparam int LVL_W   = 17;
  localparam int AMP_W   = 17;
  localparam int TOTAL_W = LEN_W + 2;
  localparam int IDX_W   = 3;

  // Divider geometry: one quotient bit per cell, remainder below the divisor
  localparam int QUO_W  = AMP_W;
  localparam int REM_W  = LEN_W;
  localparam int PROD_W = 32;

  localparam logic [AMP_W-1:0] AMP_ONE   = AMP_W'(2 ** AMP_FRAC_BITS);
  localparam logic [LEN_W-1:0] LEN_RST   = LEN_W'((2 ** TIME_FRAC_BITS + 5) / 10);
  localparam logic [LVL_W-1:0] LEVEL_RST = LVL_W'((2 ** AMP_FRAC_BITS * 8 + 5) / 10);

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_ATTACK  = 3'd0;
  localparam reg_idx_t REG_DECAY   = 3'd1;
  localparam reg_idx_t REG_HOLD    = 3'd2;
  localparam reg_idx_t REG_RELEASE = 3'd3;
  localparam reg_idx_t REG_LEVEL   = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0] attack_len;
    logic [LEN_W-1:0] decay_len;
    logic [LEN_W-1:0] hold_len;
    logic [LEN_W-1:0] release_len;
    logic [LVL_W-1:0] hold_level;
  } adsr_cfg_t;

  // What one divider cell hands to the next
  typedef struct packed {
    logic [QUO_W-1:0]   work;    // numerator bits still to shift in, quotient bits behind
    logic [REM_W-1:0]   rem;     // partial remainder
    logic [LEN_W-1:0]   div;     // segment length used as divisor, one for constant segments
    logic [AMP_W-1:0]   offset;  // added to the quotient at the end
    logic [TOTAL_W-1:0] total;   // total envelope length, carried along
  } adsr_cell_t;

endpackage

[hw/rtl/adsr_front.sv]
module adsr_front import adsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [TIME_W-1:0] query_time,
  input  adsr_cfg_t                cfg,
  output logic                     out_valid,
  output adsr_cell_t               out_data
);

  // Stage 1: segment boundaries and clamped level
  logic                 s1_valid;
  logic                 s1_neg;
  logic [TIME_W-2:0]    s1_t;
  logic [LEN_W-1:0]     s1_a;
  logic [LEN_W-1:0]     s1_d;
  logic [LEN_W-1:0]     s1_r;
  logic [LVL_W-1:0]     s1_lvl;
  logic [LEN_W:0]       s1_ad;
  logic [TOTAL_W-1:0]   s1_adh;
  logic [TOTAL_W-1:0]   s1_end;

  logic [LVL_W-1:0]     lvl_clamp;
  logic [LEN_W:0]       sum_ad;
  logic [LEN_W:0]       sum_hr;

  assign lvl_clamp = (cfg.hold_level > AMP_ONE) ? AMP_ONE : cfg.hold_level;
  assign sum_ad    = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
  assign sum_hr    = {1'b0, cfg.hold_len} + {1'b0, cfg.release_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_neg <= query_time[TIME_W-1];
    s1_t   <= query_time[TIME_W-2:0];
    s1_a   <= cfg.attack_len;
    s1_d   <= cfg.decay_len;
    s1_r   <= cfg.release_len;
    s1_lvl <= lvl_clamp;
    s1_ad  <= sum_ad;
    s1_adh <= {1'b0, sum_ad} + {2'b00, cfg.hold_len};
    s1_end <= {1'b0, sum_ad} + {1'b0, sum_hr};
  end

  // Stage 2: pick the segment and the multiply operands
  logic                 s2_valid;
  logic [AMP_W-1:0]     s2_x;
  logic [AMP_W-1:0]     s2_y;
  logic [LEN_W-1:0]     s2_div;
  logic [AMP_W-1:0]     s2_off;
  logic [TOTAL_W-1:0]   s2_total;

  logic [AMP_W-1:0]     mul_x;
  logic [AMP_W-1:0]     mul_y;
  logic [LEN_W-1:0]     div_sel;
  logic [AMP_W-1:0]     off_sel;
  logic [TOTAL_W-1:0]   dec_span;
  logic [TOTAL_W-1:0]   rel_span;

  assign dec_span = {1'b0, s1_ad} - s1_t;
  assign rel_span = s1_end - s1_t;

  always_comb begin
    // constant segments divide zero by one
    mul_x   = '0;
    mul_y   = '0;
    div_sel = LEN_W'(1);
    off_sel = '0;
    if (!s1_neg) begin
      if (s1_t < {2'b00, s1_a}) begin
        mul_x   = s1_t[AMP_W-1:0];
        mul_y   = AMP_ONE;
        div_sel = s1_a;
      end else if (s1_t < {1'b0, s1_ad}) begin
        mul_x   = AMP_ONE - s1_lvl;
        mul_y   = dec_span[AMP_W-1:0];
        div_sel = s1_d;
        off_sel = s1_lvl;
      end else if (s1_t < s1_adh) begin
        off_sel = s1_lvl;
      end else if (s1_t < s1_end) begin
        mul_x   = s1_lvl;
        mul_y   = rel_span[AMP_W-1:0];
        div_sel = s1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_x     <= mul_x;
    s2_y     <= mul_y;
    s2_div   <= div_sel;
    s2_off   <= off_sel;
    s2_total <= s1_end;
  end

  // Stage 3: multiply; the product always stays below 2^32
  logic [2*AMP_W-1:0] prod;

  assign prod = s2_x * s2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    out_data.work   <= prod[QUO_W-1:0];
    out_data.rem    <= REM_W'(prod[PROD_W-1:QUO_W]);
    out_data.div    <= s2_div;
    out_data.offset <= s2_off;
    out_data.total  <= s2_total;
  end

endmodule

[hw/rtl/adsr_div_cell.sv]
module adsr_div_cell import adsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  adsr_cell_t in_data,
  output logic       out_valid,
  output adsr_cell_t out_data
);

  logic [REM_W:0] shifted;
  logic [REM_W:0] diff;
  logic           fits;

  // bring in the next numerator bit, subtract the divisor where it fits
  assign shifted = {in_data.rem, in_data.work[QUO_W-1]};
  assign diff    = shifted - {1'b0, in_data.div};
  assign fits    = shifted >= {1'b0, in_data.div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data.work   <= {in_data.work[QUO_W-2:0], fits};
    out_data.rem    <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    out_data.div    <= in_data.div;
    out_data.offset <= in_data.offset;
    out_data.total  <= in_data.total;
  end

endmodule

[hw/rtl/adsr_envelope_amplitude.sv]
// Channel   Ports                              Handshake
// --------  ---------------------------------  -------------------------------
// item in   query_time                         start high, busy low at the edge
// result    amplitude, total_len               done high for one cycle
// config    wr_en, wr_index, wr_data           wr_en high at the edge
//
// One item is taken every cycle while busy is low. Each item passes through three
// front stages (boundaries, segment select, multiply), then the row of 17 divider
// cells (one quotient bit each), then the output register that drives done.
// Synchronous reset clears every valid flag and loads the default envelope;
// busy stays high for the cycle after reset. The receiver cannot stall.
module adsr_envelope_amplitude import adsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [TIME_W-1:0] query_time,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_index,
  input  logic [LVL_W-1:0]         wr_data,
  output logic                     done,
  output logic [AMP_W-1:0]         amplitude,
  output logic [TOTAL_W-1:0]       total_len
);

  adsr_cfg_t cfg;
  logic      accept;

  // Configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_len  <= LEN_RST;
      cfg.decay_len   <= LEN_RST;
      cfg.hold_len    <= '0;
      cfg.release_len <= LEN_RST;
      cfg.hold_level  <= LEVEL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ATTACK:  cfg.attack_len  <= wr_data[LEN_W-1:0];
        REG_DECAY:   cfg.decay_len   <= wr_data[LEN_W-1:0];
        REG_HOLD:    cfg.hold_len    <= wr_data[LEN_W-1:0];
        REG_RELEASE: cfg.release_len <= wr_data[LEN_W-1:0];
        REG_LEVEL:   cfg.hold_level  <= wr_data;
        default: ;
      endcase
    end
  end

  // Hold off items for the first cycle out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start & ~busy;

  // Front stages feed cell 0 of the divider row
  logic [QUO_W:0] chain_valid;
  adsr_cell_t     chain_data [QUO_W+1];

  adsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .query_time (query_time),
    .cfg        (cfg),
    .out_valid  (chain_valid[0]),
    .out_data   (chain_data[0])
  );

  // Row of restoring-division cells, one quotient bit per cell
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    adsr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // Add the segment offset to the quotient and register the result
  logic [AMP_W-1:0] amp_sum;

  assign amp_sum = chain_data[QUO_W].offset + chain_data[QUO_W].work;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[QUO_W];
    end
    amplitude <= amp_sum;
    total_len <= chain_data[QUO_W].total;
  end

  // An amplitude never exceeds full scale
  a_amp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> amplitude <= AMP_ONE)
    else $error("amplitude above full scale");

  // The segment select never hands a zero divisor to the divider row
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    chain_valid[0] |-> chain_data[0].div != '0)
    else $error("zero divisor entered the divider");

  // The last cell leaves a remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    chain_valid[QUO_W] |-> chain_data[QUO_W].rem < chain_data[QUO_W].div)
    else $error("divider remainder out of range");

endmodule
